// File: src/bf3_pkg.sv
// Package for the 3x3 box filter: shared types, register codes and the
// divide-by-nine helper. No dependencies.
package bf3_pkg;

    // Configuration register indexes.
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    // Geometry limits and field widths fixed by the interface.
    localparam int PIX_W     = 8;
    localparam int SUM_W     = 12;
    localparam int ROW_W     = 12;
    localparam int COL_W     = 9;
    localparam int GEOM_W    = 13;
    localparam int CFGW_W    = 10;
    localparam int MAX_ROWS  = 4096;
    localparam int MIN_DIM   = 3;

    // Result queue depth between front and back.
    localparam int QDEPTH    = 4;
    localparam int QPTR_W    = 2;
    localparam int QCNT_W    = 3;

    // Reciprocal of nine in 16 fractional bits, exact for sums below 32768.
    localparam logic [12:0] RECIP9 = 13'd7282;

    // Effective frame geometry after clamping.
    typedef struct packed {
        logic [GEOM_W-1:0] width_eff;
        logic [GEOM_W-1:0] height_eff;
    } geom_t;

    // One classified item waiting for the back end.
    typedef struct packed {
        logic [SUM_W-1:0] sum;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             last;
    } result_t;

    // Truncated division of a nine-pixel sum by nine.
    function automatic logic [PIX_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [24:0] prod;
        prod = {13'd0, s} * {12'd0, RECIP9};
        return prod[23:16];
    endfunction

endpackage

// File: src/bf3_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bf3_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 512
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Registered read port; data holds while no read is issued.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/bf3_front.sv
// Front end of the 3x3 box filter: accepts pixels, tracks row and column,
// runs the line store and the window, and pushes interior sums to the queue.
// Depends on bf3_pkg and bf3_ram.
module bf3_front #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bf3_pkg::geom_t                geom,
    input  logic                          restart,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bf3_pkg::PIX_W-1:0]     pixel_in,
    input  logic                          q_full,
    output logic                          q_push,
    output bf3_pkg::result_t              q_entry
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic                          accept;
    logic                          s1_go;
    logic [CW-1:0]                 col_reg, col_next;
    logic [bf3_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [bf3_pkg::GEOM_W-1:0]    col_ext, col_inc, row_ext, row_inc;
    logic                          col_wrap, row_wrap;

    logic                          s1_valid_reg;
    logic                          s1_out_reg;
    logic [bf3_pkg::PIX_W-1:0]     s1_px_reg;
    logic [CW-1:0]                 s1_addr_reg;
    logic [bf3_pkg::ROW_W-1:0]     s1_row_reg;
    logic [bf3_pkg::COL_W-1:0]     s1_col_reg;
    logic                          s1_last_reg;

    logic [2*bf3_pkg::PIX_W-1:0]   rd_data;
    logic [bf3_pkg::PIX_W-1:0]     up_px, mid_px;
    logic [bf3_pkg::PIX_W-1:0]     win_reg [9];
    logic [bf3_pkg::SUM_W-1:0]     win_sum;

    // Handshake: stage one blocks only when it holds a result and the queue is full.
    assign s1_go    = s1_valid_reg && !(s1_out_reg && q_full);
    assign in_stall = s1_valid_reg && s1_out_reg && q_full;
    assign accept   = in_valid && !in_stall;

    // Position arithmetic in a common compare width.
    assign col_ext  = bf3_pkg::GEOM_W'(col_reg);
    assign row_ext  = bf3_pkg::GEOM_W'(row_reg);
    assign col_inc  = col_ext + 1'b1;
    assign row_inc  = row_ext + 1'b1;
    assign col_wrap = col_inc >= geom.width_eff;
    assign row_wrap = row_inc >= geom.height_eff;

    // Next raster position.
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (col_wrap)
        begin
            col_next = '0;
            row_next = row_wrap ? '0 : bf3_pkg::ROW_W'(row_inc);
        end
        else
        begin
            col_next = CW'(col_inc);
        end
    end

    // Raster counters; a register write restarts the frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Stage one valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_go)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    // Stage one payload: the item is classified as it is accepted.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= pixel_in;
            s1_addr_reg <= col_reg;
            s1_out_reg  <= (row_reg >= bf3_pkg::ROW_W'(2)) && (col_ext >= bf3_pkg::GEOM_W'(2));
            s1_row_reg  <= row_reg - 1'b1;
            s1_col_reg  <= bf3_pkg::COL_W'(col_ext - 1'b1);
            s1_last_reg <= (row_inc == geom.height_eff) && (col_inc == geom.width_eff);
        end
    end

    // Combined line store: upper row in the high byte, middle row in the low byte.
    bf3_ram #(
        .WIDTH (2*bf3_pkg::PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_store (
        .clk   (clk),
        .we    (s1_go),
        .waddr (s1_addr_reg),
        .wdata ({mid_px, s1_px_reg}),
        .re    (accept),
        .raddr (col_reg),
        .rdata (rd_data)
    );

    assign up_px  = rd_data[2*bf3_pkg::PIX_W-1:bf3_pkg::PIX_W];
    assign mid_px = rd_data[bf3_pkg::PIX_W-1:0];

    // Window shift: column two takes the new column as stage one moves on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (restart)
        begin
            for (int k = 0; k < 9; k++)
            begin
                win_reg[k] <= '0;
            end
        end
        else if (s1_go)
        begin
            for (int k = 0; k < 3; k++)
            begin
                win_reg[k*3+0] <= win_reg[k*3+1];
                win_reg[k*3+1] <= win_reg[k*3+2];
            end
            win_reg[2] <= up_px;
            win_reg[5] <= mid_px;
            win_reg[8] <= s1_px_reg;
        end
    end

    // Sum of the window as it stands after this shift.
    assign win_sum = bf3_pkg::SUM_W'(win_reg[1]) + bf3_pkg::SUM_W'(win_reg[2])
                   + bf3_pkg::SUM_W'(win_reg[4]) + bf3_pkg::SUM_W'(win_reg[5])
                   + bf3_pkg::SUM_W'(win_reg[7]) + bf3_pkg::SUM_W'(win_reg[8])
                   + bf3_pkg::SUM_W'(up_px) + bf3_pkg::SUM_W'(mid_px)
                   + bf3_pkg::SUM_W'(s1_px_reg);

    // Queue push for interior items.
    assign q_push       = s1_go && s1_out_reg;
    assign q_entry.sum  = win_sum;
    assign q_entry.row  = s1_row_reg;
    assign q_entry.col  = s1_col_reg;
    assign q_entry.last = s1_last_reg;

    // A blocked stage one keeps its item and its line store address.
    assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_go) |=> (s1_valid_reg && $stable(s1_addr_reg)))
        else $error("stage one lost or changed a blocked item");

    // The line store is never read at the address being written back.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_go) |-> (col_reg != s1_addr_reg))
        else $error("line store read collides with write-back");

endmodule

// File: src/bf3_queue.sv
// Short result queue between the front and back ends of the box filter.
// Depends on bf3_pkg.
module bf3_queue (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  bf3_pkg::result_t push_data,
    output logic             full,
    input  logic             pop,
    output bf3_pkg::result_t pop_data,
    output logic             empty
);

    bf3_pkg::result_t              slot_reg [bf3_pkg::QDEPTH];
    logic [bf3_pkg::QPTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [bf3_pkg::QCNT_W-1:0]    count_reg, count_next;

    assign full     = count_reg == bf3_pkg::QCNT_W'(bf3_pkg::QDEPTH);
    assign empty    = count_reg == '0;
    assign pop_data = slot_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

    // The front never pushes into a full queue.
    assert property (@(posedge clk) disable iff (!rst_n) push |-> !full)
        else $error("push into full result queue");

    // The back never pops an empty queue.
    assert property (@(posedge clk) disable iff (!rst_n) pop |-> !empty)
        else $error("pop from empty result queue");

endmodule

// File: src/bf3_back.sv
// Back end of the box filter: takes queued sums, divides by nine and holds
// the result in the output register. Depends on bf3_pkg.
module bf3_back (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      q_empty,
    input  bf3_pkg::result_t          q_data,
    output logic                      q_pop,
    output logic                      out_valid,
    input  logic                      out_stall,
    output logic [bf3_pkg::PIX_W-1:0] filtered_pixel,
    output logic [bf3_pkg::ROW_W-1:0] center_row,
    output logic [bf3_pkg::COL_W-1:0] center_col,
    output logic                      frame_last
);

    logic                      out_valid_reg;
    logic [bf3_pkg::PIX_W-1:0] pix_reg;
    logic [bf3_pkg::ROW_W-1:0] row_reg;
    logic [bf3_pkg::COL_W-1:0] col_reg;
    logic                      last_reg;

    // Pop whenever the output register is empty or being taken.
    assign q_pop = !q_empty && (!out_valid_reg || !out_stall);

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (q_pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Output payload: mean by reciprocal multiply.
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            pix_reg  <= bf3_pkg::div9(q_data.sum);
            row_reg  <= q_data.row;
            col_reg  <= q_data.col;
            last_reg <= q_data.last;
        end
    end

    assign out_valid      = out_valid_reg;
    assign filtered_pixel = pix_reg;
    assign center_row     = row_reg;
    assign center_col     = col_reg;
    assign frame_last     = last_reg;

endmodule

// File: src/box_filter_3x3.sv
// Top level of the streaming 3x3 box filter: configuration registers and
// the front end, result queue and back end. Depends on bf3_pkg and all bf3_ modules.
//
// Usage: pixels enter in raster order on the input channel (in_valid,
// in_stall, pixel_in); an item is taken at a clock edge with in_valid high
// and in_stall low. For every pixel that completes a window around an
// interior centre, one item leaves on the output channel (out_valid,
// out_stall) with the truncated mean, the centre row and column, and a
// frame_last flag on the final interior item of the frame. Border pixels
// give no item.
// Throughput is one pixel per cycle while in_stall is low: the line store is read at
// the accept edge and written back through its separate write port as stage one moves
// on. Each item passes from stage one through the result queue to the output register.
// When the receiver stalls, results collect in a four-entry queue; the input
// stalls only once the queue is full and stage one holds a result.
// Writing image_width (index 0) or image_height (index 1) restarts the frame
// at row 0, column 0; write only while the block is idle. Reset sets both
// registers to 512 and restarts the frame; line store contents are not cleared
// and need no clearing pass.
module box_filter_3x3 #(
    parameter int MAX_WIDTH = 512
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic                          cfg_index,
    input  logic [bf3_pkg::GEOM_W-1:0]    cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bf3_pkg::PIX_W-1:0]     pixel_in,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bf3_pkg::PIX_W-1:0]     filtered_pixel,
    output logic [bf3_pkg::ROW_W-1:0]     center_row,
    output logic [bf3_pkg::COL_W-1:0]     center_col,
    output logic                          frame_last
);

    logic [bf3_pkg::CFGW_W-1:0]  width_reg;
    logic [bf3_pkg::GEOM_W-1:0]  height_reg;
    logic [bf3_pkg::GEOM_W-1:0]  width_ext;
    bf3_pkg::geom_t              geom;
    logic                        restart;
    logic                        q_full, q_empty, q_push, q_pop;
    bf3_pkg::result_t            q_in, q_out;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= bf3_pkg::CFGW_W'(512);
            height_reg <= bf3_pkg::GEOM_W'(512);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                bf3_pkg::REG_WIDTH:  width_reg  <= cfg_data[bf3_pkg::CFGW_W-1:0];
                bf3_pkg::REG_HEIGHT: height_reg <= cfg_data;
                default:             width_reg  <= width_reg;
            endcase
        end
    end

    // Any register write restarts the frame.
    assign restart = cfg_we;

    // Clamp the geometry to its working range.
    assign width_ext = bf3_pkg::GEOM_W'(width_reg);
    always_comb
    begin
        if (width_ext < bf3_pkg::GEOM_W'(bf3_pkg::MIN_DIM))
        begin
            geom.width_eff = bf3_pkg::GEOM_W'(bf3_pkg::MIN_DIM);
        end
        else if (width_ext > bf3_pkg::GEOM_W'(MAX_WIDTH))
        begin
            geom.width_eff = bf3_pkg::GEOM_W'(MAX_WIDTH);
        end
        else
        begin
            geom.width_eff = width_ext;
        end

        if (height_reg < bf3_pkg::GEOM_W'(bf3_pkg::MIN_DIM))
        begin
            geom.height_eff = bf3_pkg::GEOM_W'(bf3_pkg::MIN_DIM);
        end
        else if (height_reg > bf3_pkg::GEOM_W'(bf3_pkg::MAX_ROWS))
        begin
            geom.height_eff = bf3_pkg::GEOM_W'(bf3_pkg::MAX_ROWS);
        end
        else
        begin
            geom.height_eff = height_reg;
        end
    end

    // Front end: accept, classify, line store and window.
    bf3_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .geom     (geom),
        .restart  (restart),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .pixel_in (pixel_in),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (q_in)
    );

    // Result queue.
    bf3_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_out),
        .empty     (q_empty)
    );

    // Back end: divide and present.
    bf3_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (q_out),
        .q_pop          (q_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_pixel (filtered_pixel),
        .center_row     (center_row),
        .center_col     (center_col),
        .frame_last     (frame_last)
    );

endmodule

// File: verif/box_filter_3x3_tb.sv
// Self-checking testbench for box_filter_3x3: a window-mean predictor, random
// valid/stall traffic and geometry changes. Depends on bf3_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;

    localparam int LINE_MAX     = 512;
    localparam int MAX_HEIGHT   = 4096;
    localparam int DRAIN_CYCLES = 8;
    localparam int LONG_HOLD    = 120;
    localparam int STUCK_LIMIT  = 2000;
    localparam int RANDOM_ITEMS = 420;

    // One filtered pixel as it leaves the block.
    typedef struct packed {
        logic [bf3_pkg::PIX_W-1:0] mean;
        logic [bf3_pkg::ROW_W-1:0] row;
        logic [bf3_pkg::COL_W-1:0] col;
        logic                      last;
    } pix_result_t;

    // One row of the directed table; typed rows carry their own expectation.
    typedef struct packed {
        logic [bf3_pkg::PIX_W-1:0] px;
        logic                      typed;
        logic                      yields;
        pix_result_t               res;
    } stim_row_t;

    localparam pix_result_t NO_RESULT = '0;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_we;
    logic                         cfg_index;
    logic [bf3_pkg::GEOM_W-1:0]   cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic [bf3_pkg::PIX_W-1:0]    pixel_in;
    logic                         out_valid;
    logic                         out_stall;
    logic [bf3_pkg::PIX_W-1:0]    filtered_pixel;
    logic [bf3_pkg::ROW_W-1:0]    center_row;
    logic [bf3_pkg::COL_W-1:0]    center_col;
    logic                         frame_last;

    box_filter_3x3 #(.MAX_WIDTH(LINE_MAX)) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .pixel_in       (pixel_in),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .filtered_pixel (filtered_pixel),
        .center_row     (center_row),
        .center_col     (center_col),
        .frame_last     (frame_last)
    );

    // Predictor state: line stores, window, raster position and geometry.
    bit [bf3_pkg::PIX_W-1:0]  upper_line [LINE_MAX];
    bit [bf3_pkg::PIX_W-1:0]  middle_line [LINE_MAX];
    bit [bf3_pkg::PIX_W-1:0]  window_px [9];
    int                       row_pos;
    int                       col_pos;
    bit [bf3_pkg::CFGW_W-1:0] width_reg  = 10'd512;
    bit [bf3_pkg::GEOM_W-1:0] height_reg = 13'd512;

    pix_result_t awaited_means [$];
    int          fail_count = 0;
    int          idle_pct   = 0;
    int          stall_pct  = 0;
    bit          hold_wanted = 1'b0;

    // Three 3x3 frames: all white, all black, then mixed content.
    stim_row_t directed_rows [27] = '{
        '{8'd255, 1'b1, 1'b0, NO_RESULT},
        '{8'd255, 1'b1, 1'b0, NO_RESULT},
        '{8'd255, 1'b1, 1'b0, NO_RESULT},
        '{8'd255, 1'b1, 1'b0, NO_RESULT},
        '{8'd255, 1'b1, 1'b0, NO_RESULT},
        '{8'd255, 1'b1, 1'b0, NO_RESULT},
        '{8'd255, 1'b1, 1'b0, NO_RESULT},
        '{8'd255, 1'b1, 1'b0, NO_RESULT},
        '{8'd255, 1'b1, 1'b1, '{8'd255, 12'd1, 9'd1, 1'b1}},
        '{8'd0,   1'b1, 1'b0, NO_RESULT},
        '{8'd0,   1'b1, 1'b0, NO_RESULT},
        '{8'd0,   1'b1, 1'b0, NO_RESULT},
        '{8'd0,   1'b1, 1'b0, NO_RESULT},
        '{8'd0,   1'b1, 1'b0, NO_RESULT},
        '{8'd0,   1'b1, 1'b0, NO_RESULT},
        '{8'd0,   1'b1, 1'b0, NO_RESULT},
        '{8'd0,   1'b1, 1'b0, NO_RESULT},
        '{8'd0,   1'b1, 1'b1, '{8'd0, 12'd1, 9'd1, 1'b1}},
        '{8'd17,  1'b0, 1'b0, NO_RESULT},
        '{8'd200, 1'b0, 1'b0, NO_RESULT},
        '{8'd3,   1'b0, 1'b0, NO_RESULT},
        '{8'd99,  1'b0, 1'b0, NO_RESULT},
        '{8'd128, 1'b0, 1'b0, NO_RESULT},
        '{8'd0,   1'b0, 1'b0, NO_RESULT},
        '{8'd255, 1'b0, 1'b0, NO_RESULT},
        '{8'd64,  1'b0, 1'b0, NO_RESULT},
        '{8'd31,  1'b0, 1'b0, NO_RESULT}
    };

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic int clamp_dim(input int v, input int lo, input int hi);
        if (v < lo)
            return lo;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the window by one pixel and work out the mean it yields, if any.
    task automatic compute_window_mean(input logic [bf3_pkg::PIX_W-1:0] px,
                                       output bit has_result, output pix_result_t res);
        int w;
        int h;
        int sum;
        int k;
        bit [bf3_pkg::PIX_W-1:0] up;
        bit [bf3_pkg::PIX_W-1:0] mid;
        w = clamp_dim(int'(width_reg), bf3_pkg::MIN_DIM, LINE_MAX);
        h = clamp_dim(int'(height_reg), bf3_pkg::MIN_DIM, MAX_HEIGHT);
        up  = upper_line[col_pos];
        mid = middle_line[col_pos];
        for (k = 0; k < 3; k++)
        begin
            window_px[k*3]   = window_px[k*3+1];
            window_px[k*3+1] = window_px[k*3+2];
        end
        window_px[2] = up;
        window_px[5] = mid;
        window_px[8] = px;
        upper_line[col_pos]  = mid;
        middle_line[col_pos] = px;

        has_result = 1'b0;
        res = NO_RESULT;
        if (row_pos >= 2 && col_pos >= 2)
        begin
            sum = 0;
            for (k = 0; k < 9; k++)
                sum += window_px[k];
            res.mean = bf3_pkg::PIX_W'(sum / 9);
            res.row  = bf3_pkg::ROW_W'(row_pos - 1);
            res.col  = bf3_pkg::COL_W'(col_pos - 1);
            res.last = (row_pos == h - 1) && (col_pos == w - 1);
            has_result = 1'b1;
        end

        // Raster advance with wrap to the next frame.
        if (col_pos + 1 >= w)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
        end
        else
            col_pos++;
    endtask

    // Offer one pixel, possibly after an idle burst, and wait until it is taken.
    task automatic send_pixel(input logic [bf3_pkg::PIX_W-1:0] px);
        if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_in <= px;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Wait for the block to drain, then write both geometry registers.
    task automatic load_geometry(input logic [bf3_pkg::GEOM_W-1:0] wdata,
                                 input logic [bf3_pkg::GEOM_W-1:0] hdata);
        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= bf3_pkg::REG_WIDTH;
        cfg_data  <= wdata;
        @(posedge clk);
        cfg_index <= bf3_pkg::REG_HEIGHT;
        cfg_data  <= hdata;
        @(posedge clk);
        cfg_we <= 1'b0;

        // Any register write restarts the frame; line stores are kept.
        width_reg  = wdata[bf3_pkg::CFGW_W-1:0];
        height_reg = hdata;
        foreach (window_px[k])
            window_px[k] = '0;
        row_pos = 0;
        col_pos = 0;
    endtask

    // One geometry setting followed by a run of random pixels.
    task automatic run_phase(input logic [bf3_pkg::GEOM_W-1:0] wdata,
                             input logic [bf3_pkg::GEOM_W-1:0] hdata,
                             input int count, input int send_idle, input int recv_stall,
                             input bit pause_mid);
        int i;
        logic [bf3_pkg::PIX_W-1:0] px;
        bit got;
        pix_result_t res;
        load_geometry(wdata, hdata);
        idle_pct  = send_idle;
        stall_pct = recv_stall;
        for (i = 0; i < count; i++)
        begin
            // Sender holds off until every pending result has come out.
            if (pause_mid && i == count / 2)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (awaited_means.size() != 0)
                    @(posedge clk);
            end
            case ($urandom_range(0, 7))
                0:       px = '0;
                1:       px = '1;
                default: px = bf3_pkg::PIX_W'($urandom_range(0, 255));
            endcase
            send_pixel(px);
            compute_window_mean(px, got, res);
            if (got)
                awaited_means.push_back(res);
        end
    endtask

    // Stimulus: directed table, pressure phases, random phases.
    initial
    begin
        int i;
        int n;
        int w;
        int h;
        int random_items;
        bit got;
        pix_result_t res;
        stim_row_t item;

        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_index = bf3_pkg::REG_WIDTH;
        cfg_data  = '0;
        in_valid  = 1'b0;
        pixel_in  = '0;
        row_pos   = 0;
        col_pos   = 0;
        foreach (window_px[k])
            window_px[k] = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part on the smallest frame.
        load_geometry(13'd3, 13'd3);
        idle_pct  = 10;
        stall_pct = 10;
        for (i = 0; i < 27; i++)
        begin
            item = directed_rows[i];
            send_pixel(item.px);
            compute_window_mean(item.px, got, res);
            if (item.typed)
            begin
                if (item.yields)
                    awaited_means.push_back(item.res);
            end
            else if (got)
                awaited_means.push_back(res);
        end

        // Width masked to its low bits, below-minimum values acting as three.
        run_phase(13'h1C02, 13'd0, 45, 20, 10, 1'b0);

        // Receiver holds off for a long stretch while the sender keeps offering.
        hold_wanted = 1'b1;
        run_phase(13'd4, 13'd8, 150, 0, 0, 1'b0);

        // Sender pauses mid-phase until the block has drained.
        run_phase(13'd9, 13'd5, 100, 20, 15, 1'b1);

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            w = $urandom_range(0, 20);
            h = $urandom_range(0, 12);
            n = clamp_dim(w, bf3_pkg::MIN_DIM, LINE_MAX)
              * clamp_dim(h, bf3_pkg::MIN_DIM, MAX_HEIGHT) * 3;
            n = $urandom_range(8, (n < 150) ? n : 150);
            run_phase({3'($urandom_range(0, 7)), 10'(w)}, 13'(h), n,
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 30),
                      ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(5, 20), 1'b0);
            random_items += n;
        end

        // Final stretch at full rate on both sides.
        run_phase(13'd6, 13'd4, 48, 0, 0, 1'b0);

        in_valid <= 1'b0;
        @(posedge clk);
        while (awaited_means.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    // Receiver: checks each accepted item and drives stall bursts.
    initial
    begin
        int stall_left;
        bit hold_taken;
        pix_result_t want;
        stall_left = 0;
        hold_taken = 1'b0;
        out_stall  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                if (awaited_means.size() == 0)
                begin
                    $error("unexpected item: filtered_pixel %0d center_row %0d center_col %0d",
                           filtered_pixel, center_row, center_col);
                    fail_count++;
                end
                else
                begin
                    want = awaited_means.pop_front();
                    if (filtered_pixel !== want.mean)
                    begin
                        $error("filtered_pixel: expected %0d, actual %0d",
                               want.mean, filtered_pixel);
                        fail_count++;
                    end
                    if (center_row !== want.row)
                    begin
                        $error("center_row: expected %0d, actual %0d", want.row, center_row);
                        fail_count++;
                    end
                    if (center_col !== want.col)
                    begin
                        $error("center_col: expected %0d, actual %0d", want.col, center_col);
                        fail_count++;
                    end
                    if (frame_last !== want.last)
                    begin
                        $error("frame_last: expected %0d, actual %0d", want.last, frame_last);
                        fail_count++;
                    end
                end
            end

            // Decide the stall for the next cycle.
            if (hold_wanted && !hold_taken)
            begin
                hold_taken = 1'b1;
                stall_left = LONG_HOLD;
            end
            else if (stall_left == 0 && stall_pct > 0 && $urandom_range(0, 99) < stall_pct)
                stall_left = $urandom_range(1, 19);
            if (stall_left > 0)
            begin
                out_stall <= 1'b1;
                stall_left--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    // Watchdog on cycles in which neither channel nor the config port moves.
    initial
    begin
        int stuck_cycles;
        stuck_cycles = 0;
        while (stuck_cycles < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
                stuck_cycles = 0;
            else
                stuck_cycles++;
        end
        $display("CHECK FAILED");
        $finish;
    end

endmodule
